### design/tcd_pkg.sv
`timescale 1ns / 1ps
// Shared types for the capacitive touch detector: sequencer states and sorter cell control.
package tcd_pkg;

  // Sequencer states of the top level.
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SUM,
    ST_DIV,
    ST_OUT
  } tcd_state_t;

  // Control broadcast to every sorter cell.
  typedef struct packed {
    logic insert;
    logic shift;
  } tcd_cell_ctl_t;

  // Reset value of the lockout reload register.
  localparam logic [3:0] LOCKOUT_RELOAD_RST = 4'd3;

endpackage

### design/tcd_cell.sv
`timescale 1ns / 1ps
// One cell of the insertion sorter chain: holds a single calibration sample.
module tcd_cell #(
  parameter int SAMPLE_BITS = 32
) (
  input  logic                      clk,
  input  tcd_pkg::tcd_cell_ctl_t    ctl,
  input  logic                      occupied,
  input  logic [SAMPLE_BITS-1:0]    new_val,
  input  logic [SAMPLE_BITS-1:0]    left_val,
  input  logic                      left_lt,
  input  logic [SAMPLE_BITS-1:0]    right_val,
  output logic [SAMPLE_BITS-1:0]    val_o,
  output logic                      lt_o
);
  import tcd_pkg::*;

  logic [SAMPLE_BITS-1:0] val_r;
  logic [SAMPLE_BITS-1:0] val_nxt;
  logic                   load;

  // An empty cell counts as holding a value above every sample.
  assign lt_o = !occupied || (new_val < val_r);

  always_comb begin
    val_nxt = val_r;
    load    = 1'b0;
    if (ctl.insert && lt_o) begin
      // The new item lands here if the left neighbour keeps its value,
      // otherwise the left neighbour's value moves right into this cell.
      val_nxt = left_lt ? left_val : new_val;
      load    = 1'b1;
    end else if (ctl.shift) begin
      val_nxt = right_val;
      load    = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      val_r <= val_nxt;
    end
  end

  assign val_o = val_r;

endmodule

### design/tcd_div.sv
`timescale 1ns / 1ps
// Divider by a fixed divisor: a reciprocal multiplication worked through one chunk per cycle.
module tcd_div #(
  parameter int DIVIDEND_W = 36,
  parameter int DIVISOR    = 6,
  parameter int QUOT_W     = 32
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  start,
  input  logic [DIVIDEND_W-1:0] dividend,
  output logic                  done,
  output logic [QUOT_W-1:0]     quotient
);
  import tcd_pkg::*;

  // The quotient is floor(dividend * RECIP / 2^SHIFT), with RECIP the
  // reciprocal of the divisor rounded up. The rounding error stays below
  // one part in the divisor, so this is exact for every DIVIDEND_W-bit
  // dividend. The product is built most significant chunk first, and the
  // quotient is ready when done goes high.
  localparam int          CHUNK_W    = 12;
  localparam int          N_CHUNK    = (DIVIDEND_W + CHUNK_W - 1) / CHUNK_W;
  localparam int          PAD_W      = N_CHUNK * CHUNK_W;
  localparam int          SHIFT      = DIVIDEND_W + $clog2(DIVISOR);
  localparam int          RECIP_W    = DIVIDEND_W + 1;
  localparam logic [63:0] RECIP_WIDE =
    ((64'd1 << SHIFT) + 64'(DIVISOR) - 64'd1) / 64'(DIVISOR);
  localparam logic [RECIP_W-1:0] RECIP = RECIP_WIDE[RECIP_W-1:0];
  localparam int          PART_W     = CHUNK_W + RECIP_W;
  localparam int          PROD_W     = PAD_W + RECIP_W;
  localparam int          CNT_W      = $clog2(N_CHUNK + 1);

  logic [PAD_W-1:0]        num_r;
  logic [PAD_W-1:0]        num_nxt;
  logic [PROD_W-1:0]       prod_r;
  logic [PROD_W-1:0]       prod_nxt;
  logic [CNT_W-1:0]        cnt_r;
  logic [CNT_W-1:0]        cnt_nxt;
  logic                    run_r;
  logic                    run_nxt;
  logic                    done_r;
  logic                    done_nxt;
  logic [CHUNK_W-1:0]      chunk;
  logic [PART_W-1:0]       part;
  logic [PROD_W-SHIFT-1:0] quot_full;

  assign chunk = num_r[PAD_W-1 -: CHUNK_W];
  // One chunk of the dividend times the constant reciprocal.
  assign part  = {{RECIP_W{1'b0}}, chunk} * {{CHUNK_W{1'b0}}, RECIP};

  always_comb begin
    num_nxt  = num_r;
    prod_nxt = prod_r;
    cnt_nxt  = cnt_r;
    run_nxt  = run_r;
    done_nxt = 1'b0;
    if (start) begin
      num_nxt  = PAD_W'(dividend);
      prod_nxt = '0;
      cnt_nxt  = '0;
      run_nxt  = 1'b1;
    end else if (run_r) begin
      // Horner's scheme: shift the partial product up by one chunk and add
      // the next chunk's product.
      prod_nxt = (prod_r << CHUNK_W) + PROD_W'(part);
      num_nxt  = num_r << CHUNK_W;
      cnt_nxt  = cnt_r + 1'b1;
      if (cnt_r == CNT_W'(N_CHUNK - 1)) begin
        run_nxt  = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_r  <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      run_r  <= run_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    num_r  <= num_nxt;
    prod_r <= prod_nxt;
  end

  assign quot_full = prod_r[PROD_W-1:SHIFT];
  assign done      = done_r;
  assign quotient  = quot_full[QUOT_W-1:0];

endmodule

### design/capacitive_touch_detector_core.sv
`timescale 1ns / 1ps
// Top level of the capacitive touch detector with a trimmed-mean baseline.
//
// The block takes one pad charge time per item. The first CAL_SAMPLES items
// calibrate: each is inserted in sorted order into a chain of CAL_SAMPLES
// cells in the cycle it is accepted. When the last one arrives the chain
// shifts its contents out through cell zero, the entries between the trimmed
// ends are summed, and a divider that multiplies the sum by the rounded-up
// reciprocal of the entry count, twelve bits of the sum per cycle, forms the
// truncated mean; that mean becomes the baseline. Every later item is a touch
// when three times the sample exceeds four times the baseline and the sample
// is below ten times the baseline. A touch toggles the indicator only while
// the lockout count is zero and always reloads the count with one less than
// the lockout_reload register (zero stays zero); a nonzero count then steps
// down once per item that is not a touch. An ordinary item is accepted in
// idle and its result is then loaded into the output register once that
// register is free, and the next item can be accepted while that result
// still waits to be taken. The final calibration item first runs the chain
// read-out and the divider before its result is loaded.
// The configuration register may be written at any time the block is idle;
// cfg_ready is always high.
module capacitive_touch_detector_core #(
  parameter int CAL_SAMPLES   = 10,
  parameter int TRIM_EACH_END = 2,
  parameter int SAMPLE_BITS   = 32
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [31:0] in_charge_ticks,
  output logic        out_valid,
  input  logic        out_stall,
  output logic        out_touch_toggle,
  output logic        out_indicator_level,
  output logic        out_calibrating,
  output logic [31:0] out_baseline_ticks,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [3:0]  cfg_data
);
  import tcd_pkg::*;

  localparam int CNT_W     = $clog2(CAL_SAMPLES + 1);
  localparam int IDX_W     = $clog2(CAL_SAMPLES);
  localparam int SUM_W     = SAMPLE_BITS + $clog2(CAL_SAMPLES);
  localparam int KEEP_I    = CAL_SAMPLES - 2 * TRIM_EACH_END;
  localparam bit HAS_KEEP  = KEEP_I > 0;
  localparam int KEEP      = HAS_KEEP ? KEEP_I : 1;
  localparam int KEEP_HI   = CAL_SAMPLES - TRIM_EACH_END;

  // Sequencer and channel state.
  tcd_state_t             state_r;
  tcd_state_t             state_nxt;
  logic                   out_valid_r;
  logic                   out_valid_nxt;
  logic                   out_toggle_r;
  logic                   out_level_r;
  logic                   out_cal_r;
  logic [SAMPLE_BITS-1:0] out_base_r;
  logic                   out_load;

  // Pending result bits of the item in flight.
  logic                   pend_toggle_r;
  logic                   pend_toggle_nxt;
  logic                   pend_cal_r;
  logic                   pend_cal_nxt;

  // Detector state.
  logic [CNT_W-1:0]       cal_cnt_r;
  logic [CNT_W-1:0]       cal_cnt_nxt;
  logic [SAMPLE_BITS-1:0] baseline_r;
  logic [SAMPLE_BITS-1:0] baseline_nxt;
  logic [3:0]             lockout_r;
  logic [3:0]             lockout_nxt;
  logic                   indicator_r;
  logic                   indicator_nxt;
  logic [3:0]             lockout_reload_r;

  // Read-out and mean.
  logic [IDX_W-1:0]       sum_idx_r;
  logic [IDX_W-1:0]       sum_idx_nxt;
  logic [SUM_W-1:0]       acc_r;
  logic [SUM_W-1:0]       acc_nxt;
  logic                   div_start;
  logic                   div_done;
  logic [SAMPLE_BITS-1:0] div_quot;

  // Sorter chain.
  tcd_cell_ctl_t          cell_ctl;
  logic [SAMPLE_BITS-1:0] cell_val [CAL_SAMPLES];
  logic                   cell_lt  [CAL_SAMPLES];

  logic                   in_accept;
  logic [SAMPLE_BITS-1:0] sample;
  logic                   calibrating;
  logic                   touch;
  logic [SAMPLE_BITS+1:0] sample_x3;
  logic [SAMPLE_BITS+1:0] base_x4;
  logic [SAMPLE_BITS+3:0] base_x10;
  logic                   in_keep;

  assign in_stall    = state_r != ST_IDLE;
  assign in_accept   = in_valid && !in_stall;
  assign sample      = in_charge_ticks[SAMPLE_BITS-1:0];
  assign calibrating = cal_cnt_r != CNT_W'(CAL_SAMPLES);
  assign cfg_ready   = 1'b1;

  // sample > floor(4b/3) is the same as 3*sample > 4b for integers, so no
  // division is needed; all terms are kept wide enough not to wrap.
  assign sample_x3 = {2'b00, sample} + {1'b0, sample, 1'b0};
  assign base_x4   = {baseline_r, 2'b00};
  assign base_x10  = {1'b0, baseline_r, 3'b000} + {3'b000, baseline_r, 1'b0};
  assign touch     = (sample_x3 > base_x4) && ({4'b0000, sample} < base_x10);

  assign in_keep = (int'(sum_idx_r) >= TRIM_EACH_END) && (int'(sum_idx_r) < KEEP_HI);

  genvar gi;
  generate
    for (gi = 0; gi < CAL_SAMPLES; gi++) begin : g_cell
      logic [SAMPLE_BITS-1:0] left_val;
      logic                   left_lt;
      logic [SAMPLE_BITS-1:0] right_val;
      logic                   occupied;

      if (gi == 0) begin : g_first
        assign left_val = '0;
        assign left_lt  = 1'b0;
      end else begin : g_inner
        assign left_val = cell_val[gi-1];
        assign left_lt  = cell_lt[gi-1];
      end

      if (gi == CAL_SAMPLES - 1) begin : g_last
        assign right_val = '0;
      end else begin : g_mid
        assign right_val = cell_val[gi+1];
      end

      assign occupied = CNT_W'(gi) < cal_cnt_r;

      tcd_cell #(
        .SAMPLE_BITS (SAMPLE_BITS)
      ) u_cell (
        .clk       (clk),
        .ctl       (cell_ctl),
        .occupied  (occupied),
        .new_val   (sample),
        .left_val  (left_val),
        .left_lt   (left_lt),
        .right_val (right_val),
        .val_o     (cell_val[gi]),
        .lt_o      (cell_lt[gi])
      );
    end
  endgenerate

  tcd_div #(
    .DIVIDEND_W (SUM_W),
    .DIVISOR    (KEEP),
    .QUOT_W     (SAMPLE_BITS)
  ) u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (acc_r),
    .done     (div_done),
    .quotient (div_quot)
  );

  // Sequencer: accepts an item in idle, runs the calibration read-out and
  // division when the last calibration item arrives, then hands the result
  // to the output register as soon as that register is free.
  always_comb begin
    state_nxt       = state_r;
    cal_cnt_nxt     = cal_cnt_r;
    baseline_nxt    = baseline_r;
    lockout_nxt     = lockout_r;
    indicator_nxt   = indicator_r;
    pend_toggle_nxt = pend_toggle_r;
    pend_cal_nxt    = pend_cal_r;
    sum_idx_nxt     = sum_idx_r;
    acc_nxt         = acc_r;
    div_start       = 1'b0;
    out_load        = 1'b0;
    cell_ctl.insert = 1'b0;
    cell_ctl.shift  = 1'b0;

    unique case (state_r)
      ST_IDLE: begin
        if (in_accept) begin
          pend_cal_nxt = calibrating;
          if (calibrating) begin
            cell_ctl.insert = 1'b1;
            cal_cnt_nxt     = cal_cnt_r + 1'b1;
            pend_toggle_nxt = 1'b0;
            if (cal_cnt_r == CNT_W'(CAL_SAMPLES - 1)) begin
              sum_idx_nxt = '0;
              acc_nxt     = '0;
              state_nxt   = ST_SUM;
            end else begin
              state_nxt = ST_OUT;
            end
          end else begin
            pend_toggle_nxt = touch && (lockout_r == 4'd0);
            if (touch && (lockout_r == 4'd0)) begin
              indicator_nxt = !indicator_r;
            end
            if (touch) begin
              lockout_nxt = (lockout_reload_r != 4'd0) ? lockout_reload_r - 4'd1 : 4'd0;
            end else if (lockout_r != 4'd0) begin
              lockout_nxt = lockout_r - 4'd1;
            end
            state_nxt = ST_OUT;
          end
        end
      end
      ST_SUM: begin
        // Sorted entries leave through cell zero, smallest first.
        cell_ctl.shift = 1'b1;
        if (in_keep) begin
          acc_nxt = acc_r + SUM_W'(cell_val[0]);
        end
        sum_idx_nxt = sum_idx_r + 1'b1;
        if (sum_idx_r == IDX_W'(CAL_SAMPLES - 1)) begin
          // The index restarts at zero so that the divider start below sees it.
          sum_idx_nxt = '0;
          if (HAS_KEEP) begin
            state_nxt = ST_DIV;
          end else begin
            baseline_nxt = '0;
            state_nxt    = ST_OUT;
          end
        end
      end
      ST_DIV: begin
        // The divider is started on the first cycle here; acc_r is final.
        div_start = (sum_idx_r == '0) && !div_done;
        if (div_start) begin
          sum_idx_nxt = IDX_W'(1);
        end
        if (div_done) begin
          baseline_nxt = div_quot;
          state_nxt    = ST_OUT;
        end
      end
      ST_OUT: begin
        if (!out_valid_r || !out_stall) begin
          out_load  = 1'b1;
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  assign out_valid_nxt = out_load ? 1'b1 : (out_valid_r && out_stall);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r          <= ST_IDLE;
      out_valid_r      <= 1'b0;
      cal_cnt_r        <= '0;
      baseline_r       <= '0;
      lockout_r        <= 4'd0;
      indicator_r      <= 1'b1;
      lockout_reload_r <= LOCKOUT_RELOAD_RST;
      sum_idx_r        <= '0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      cal_cnt_r   <= cal_cnt_nxt;
      baseline_r  <= baseline_nxt;
      lockout_r   <= lockout_nxt;
      indicator_r <= indicator_nxt;
      sum_idx_r   <= sum_idx_nxt;
      if (cfg_valid && cfg_ready) begin
        lockout_reload_r <= cfg_data;
      end
    end
  end

  // Payload registers carry no reset.
  always_ff @(posedge clk) begin
    pend_toggle_r <= pend_toggle_nxt;
    pend_cal_r    <= pend_cal_nxt;
    acc_r         <= acc_nxt;
    if (out_load) begin
      out_toggle_r <= pend_toggle_r;
      out_level_r  <= indicator_r;
      out_cal_r    <= pend_cal_r;
      out_base_r   <= baseline_r;
    end
  end

  assign out_valid           = out_valid_r;
  assign out_touch_toggle    = out_toggle_r;
  assign out_indicator_level = out_level_r;
  assign out_calibrating     = out_cal_r;
  assign out_baseline_ticks  = 32'(out_base_r);

`ifndef SYNTH
  // The calibration count never runs past the number of calibration items.
  a_cal_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cal_cnt_r <= CNT_W'(CAL_SAMPLES))
    else $error("calibration count overran");

  // The divider only ever runs once calibration has taken every item.
  a_div_after_cal: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_DIV) |-> (cal_cnt_r == CNT_W'(CAL_SAMPLES)))
    else $error("mean computed before calibration completed");

  // A calibration result never reports a toggle.
  a_cal_no_toggle: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_calibrating) |-> !out_touch_toggle)
    else $error("toggle reported during calibration");

  // With a zero baseline no item can be a touch.
  a_zero_base_no_toggle: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && (out_baseline_ticks == 32'd0)) |-> !out_touch_toggle)
    else $error("toggle reported with zero baseline");

  // An accepted detection item flips the indicator exactly when it toggles.
  a_toggle_flips: assert property (@(posedge clk) disable iff (!rst_n)
    (in_accept && !calibrating) |=> (indicator_r != $past(indicator_r)) == pend_toggle_r)
    else $error("indicator change disagrees with toggle");
`endif

endmodule
